/* rtl/c6502_pkg.sv */
// c6502_pkg: types, opcode constants and decode function for the 6502 subset core.
// No dependencies; used by every other file of the block but c6502_in_if.
package c6502_pkg;

  localparam int AddrBits = 16;
  localparam int MemDepth = 1 << AddrBits;
  localparam int ClrCountBits = AddrBits + 1;

  typedef enum logic [1:0] {
    SEL_WRITE = 2'd0,
    SEL_EXEC  = 2'd1,
    SEL_SETPC = 2'd2,
    SEL_NONE  = 2'd3
  } sel_t;

  typedef enum logic [2:0] {
    K_NONE, K_ADC, K_LDA, K_LDX, K_LDY
  } kind_t;

  typedef enum logic [3:0] {
    M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABSX, M_ABSY, M_INDX, M_INDY
  } mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_OPC, ST_LO, ST_HI, ST_PTRLO, ST_PTRHI, ST_VAL, ST_EXEC, ST_OUT
  } state_t;

  // Memory address source chosen by the controller.
  typedef enum logic [2:0] {
    AS_PC, AS_ZP, AS_ZP1, AS_EFF, AS_CLR, AS_IN
  } asel_t;

  typedef struct packed {
    logic   mem_we;
    asel_t  asel;
    logic   mem_re;
    logic   load_in;
    logic   pc_inc;
    logic   pc_load;
    logic   cap_op;
    logic   cap_lo;
    logic   cap_plo;
    logic   cap_val;
    logic   exec;
    logic   set_unk;
    logic   clr_inc;
  } ctl_t;

  typedef struct packed {
    kind_t  kind;
    mode_t  mode;
    logic   clr_done;
  } sts_t;

  localparam logic [7:0] OP_ADC_IMM = 8'h69, OP_ADC_ZP = 8'h65, OP_ADC_ZPX = 8'h75,
    OP_ADC_ABS = 8'h6D, OP_ADC_ABSX = 8'h7D, OP_ADC_ABSY = 8'h79, OP_ADC_INDX = 8'h61,
    OP_ADC_INDY = 8'h71;
  localparam logic [7:0] OP_LDA_IMM = 8'hA9, OP_LDA_ZP = 8'hA5, OP_LDA_ZPX = 8'hB5,
    OP_LDA_ABS = 8'hAD, OP_LDA_ABSX = 8'hBD, OP_LDA_ABSY = 8'hB9, OP_LDA_INDX = 8'hA1,
    OP_LDA_INDY = 8'hB1;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2, OP_LDX_ZP = 8'hA6, OP_LDX_ZPY = 8'hB6,
    OP_LDX_ABS = 8'hAE, OP_LDX_ABSY = 8'hBE;
  localparam logic [7:0] OP_LDY_IMM = 8'hA0, OP_LDY_ZP = 8'hA4, OP_LDY_ZPX = 8'hB4,
    OP_LDY_ABS = 8'hAC, OP_LDY_ABSX = 8'hBC;

  function automatic logic [6:0] decode(input logic [7:0] op);
    kind_t k;
    mode_t m;
    k = K_NONE;
    m = M_IMM;
    unique case (op)
      OP_ADC_IMM:  begin k = K_ADC; m = M_IMM;  end
      OP_ADC_ZP:   begin k = K_ADC; m = M_ZP;   end
      OP_ADC_ZPX:  begin k = K_ADC; m = M_ZPX;  end
      OP_ADC_ABS:  begin k = K_ADC; m = M_ABS;  end
      OP_ADC_ABSX: begin k = K_ADC; m = M_ABSX; end
      OP_ADC_ABSY: begin k = K_ADC; m = M_ABSY; end
      OP_ADC_INDX: begin k = K_ADC; m = M_INDX; end
      OP_ADC_INDY: begin k = K_ADC; m = M_INDY; end
      OP_LDA_IMM:  begin k = K_LDA; m = M_IMM;  end
      OP_LDA_ZP:   begin k = K_LDA; m = M_ZP;   end
      OP_LDA_ZPX:  begin k = K_LDA; m = M_ZPX;  end
      OP_LDA_ABS:  begin k = K_LDA; m = M_ABS;  end
      OP_LDA_ABSX: begin k = K_LDA; m = M_ABSX; end
      OP_LDA_ABSY: begin k = K_LDA; m = M_ABSY; end
      OP_LDA_INDX: begin k = K_LDA; m = M_INDX; end
      OP_LDA_INDY: begin k = K_LDA; m = M_INDY; end
      OP_LDX_IMM:  begin k = K_LDX; m = M_IMM;  end
      OP_LDX_ZP:   begin k = K_LDX; m = M_ZP;   end
      OP_LDX_ZPY:  begin k = K_LDX; m = M_ZPY;  end
      OP_LDX_ABS:  begin k = K_LDX; m = M_ABS;  end
      OP_LDX_ABSY: begin k = K_LDX; m = M_ABSY; end
      OP_LDY_IMM:  begin k = K_LDY; m = M_IMM;  end
      OP_LDY_ZP:   begin k = K_LDY; m = M_ZP;   end
      OP_LDY_ZPX:  begin k = K_LDY; m = M_ZPX;  end
      OP_LDY_ABS:  begin k = K_LDY; m = M_ABS;  end
      OP_LDY_ABSX: begin k = K_LDY; m = M_ABSX; end
      default:     begin k = K_NONE; m = M_IMM; end
    endcase
    return {k, m};
  endfunction

endpackage

/* rtl/c6502_in_if.sv */
// c6502_in_if / c6502_out_if: valid-ready channels of the core.
// Depends on nothing.
interface c6502_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] address;
  logic [7:0]  data;
  modport source (output valid, opcode, address, data, input ready);
  modport sink (input valid, opcode, address, data, output ready);
endinterface

interface c6502_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] program_counter;
  logic [7:0]  accumulator;
  logic [7:0]  index_x;
  logic [7:0]  index_y;
  logic        carry_flag;
  logic        zero_flag;
  logic        overflow_flag;
  logic        negative_flag;
  logic        unknown_opcode;
  modport source (output valid, program_counter, accumulator, index_x, index_y,
    carry_flag, zero_flag, overflow_flag, negative_flag, unknown_opcode, input ready);
  modport sink (input valid, program_counter, accumulator, index_x, index_y,
    carry_flag, zero_flag, overflow_flag, negative_flag, unknown_opcode, output ready);
endinterface

/* rtl/c6502_ctrl.sv */
// c6502_ctrl: sequencer that steps one item through its memory reads.
// Depends on c6502_pkg.
module c6502_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_sel,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  c6502_pkg::sts_t      sts,
  output c6502_pkg::ctl_t      ctl
);
  c6502_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= c6502_pkg::ST_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    ctl.asel = c6502_pkg::AS_PC;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      c6502_pkg::ST_CLEAR: begin
        // sweep the memory to zero, one byte a cycle
        ctl.mem_we = 1'b1;
        ctl.asel = c6502_pkg::AS_CLR;
        ctl.clr_inc = 1'b1;
        if (sts.clr_done) state_nxt = c6502_pkg::ST_IDLE;
      end
      c6502_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load_in = 1'b1;
          unique case (in_sel)
            c6502_pkg::SEL_WRITE: begin
              ctl.mem_we = 1'b1;
              ctl.asel = c6502_pkg::AS_IN;
              state_nxt = c6502_pkg::ST_OUT;
            end
            c6502_pkg::SEL_EXEC: begin
              ctl.mem_re = 1'b1;
              ctl.pc_inc = 1'b1;
              state_nxt = c6502_pkg::ST_OPC;
            end
            c6502_pkg::SEL_SETPC: begin
              ctl.pc_load = 1'b1;
              state_nxt = c6502_pkg::ST_OUT;
            end
            default: state_nxt = c6502_pkg::ST_OUT;
          endcase
        end
      end
      c6502_pkg::ST_OPC: begin
        ctl.cap_op = 1'b1;
        if (sts.kind == c6502_pkg::K_NONE) begin
          ctl.set_unk = 1'b1;
          state_nxt = c6502_pkg::ST_OUT;
        end else begin
          ctl.mem_re = 1'b1;
          ctl.pc_inc = 1'b1;
          state_nxt = c6502_pkg::ST_LO;
        end
      end
      c6502_pkg::ST_LO: begin
        ctl.cap_lo = 1'b1;
        unique case (sts.mode)
          c6502_pkg::M_IMM: state_nxt = c6502_pkg::ST_EXEC;
          c6502_pkg::M_ABS, c6502_pkg::M_ABSX, c6502_pkg::M_ABSY: begin
            ctl.mem_re = 1'b1;
            ctl.pc_inc = 1'b1;
            state_nxt = c6502_pkg::ST_HI;
          end
          c6502_pkg::M_INDX, c6502_pkg::M_INDY: begin
            ctl.mem_re = 1'b1;
            ctl.asel = c6502_pkg::AS_ZP;
            state_nxt = c6502_pkg::ST_PTRLO;
          end
          default: begin
            ctl.mem_re = 1'b1;
            ctl.asel = c6502_pkg::AS_EFF;
            state_nxt = c6502_pkg::ST_VAL;
          end
        endcase
      end
      c6502_pkg::ST_HI: begin
        ctl.mem_re = 1'b1;
        ctl.asel = c6502_pkg::AS_EFF;
        state_nxt = c6502_pkg::ST_VAL;
      end
      c6502_pkg::ST_PTRLO: begin
        ctl.cap_plo = 1'b1;
        ctl.mem_re = 1'b1;
        ctl.asel = c6502_pkg::AS_ZP1;
        state_nxt = c6502_pkg::ST_PTRHI;
      end
      c6502_pkg::ST_PTRHI: begin
        ctl.mem_re = 1'b1;
        ctl.asel = c6502_pkg::AS_EFF;
        state_nxt = c6502_pkg::ST_VAL;
      end
      c6502_pkg::ST_VAL: begin
        ctl.cap_val = 1'b1;
        state_nxt = c6502_pkg::ST_EXEC;
      end
      c6502_pkg::ST_EXEC: begin
        ctl.exec = 1'b1;
        state_nxt = c6502_pkg::ST_OUT;
      end
      c6502_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = c6502_pkg::ST_IDLE;
      end
      default: state_nxt = c6502_pkg::ST_IDLE;
    endcase
  end
endmodule

/* rtl/c6502_dp.sv */
// c6502_dp: registers, byte memory, address generation and ALU of the core.
// Depends on c6502_pkg.
module c6502_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  c6502_pkg::ctl_t      ctl,
  output c6502_pkg::sts_t      sts,
  input  logic [1:0]           in_sel,
  input  logic [15:0]          in_address,
  input  logic [7:0]           in_data,
  output logic [15:0]          pc,
  output logic [7:0]           acc,
  output logic [7:0]           xr,
  output logic [7:0]           yr,
  output logic [3:0]           flags,
  output logic                 unk
);
  logic [7:0] mem [c6502_pkg::MemDepth];
  logic [7:0] rdata_r;
  logic [c6502_pkg::ClrCountBits-1:0] clr_r;
  logic [15:0] pc_r;
  logic [7:0] acc_r, x_r, y_r;
  logic [3:0] flags_r; // N V Z C
  logic unk_r;
  logic [7:0] op_r, lo_r, plo_r, val_r;
  logic [6:0] dec;
  c6502_pkg::kind_t kind;
  c6502_pkg::mode_t mode;
  logic [15:0] eff, addr;
  logic [7:0] zp;
  logic [8:0] sum;
  logic [7:0] res;
  logic [7:0] lo_v;

  assign dec  = c6502_pkg::decode(ctl.cap_op ? rdata_r : op_r);
  assign kind = c6502_pkg::kind_t'(dec[6:4]);
  assign mode = c6502_pkg::mode_t'(dec[3:0]);
  assign sts.kind = kind;
  assign sts.mode = mode;
  assign sts.clr_done = (clr_r == c6502_pkg::ClrCountBits'(c6502_pkg::MemDepth - 1));

  // lo comes straight from the read port while it is captured
  assign lo_v = ctl.cap_lo ? rdata_r : lo_r;
  assign zp = (mode == c6502_pkg::M_INDX) ? lo_v + x_r : lo_v;

  always_comb begin
    unique case (mode)
      c6502_pkg::M_ZP:   eff = {8'h00, lo_v};
      c6502_pkg::M_ZPX:  eff = {8'h00, 8'(lo_v + x_r)};
      c6502_pkg::M_ZPY:  eff = {8'h00, 8'(lo_v + y_r)};
      c6502_pkg::M_ABS:  eff = {rdata_r, lo_r};
      c6502_pkg::M_ABSX: eff = {rdata_r, lo_r} + {8'h00, x_r};
      c6502_pkg::M_ABSY: eff = {rdata_r, lo_r} + {8'h00, y_r};
      c6502_pkg::M_INDX: eff = {rdata_r, plo_r};
      c6502_pkg::M_INDY: eff = {rdata_r, plo_r} + {8'h00, y_r};
      default:           eff = {8'h00, lo_v};
    endcase
  end

  always_comb begin
    unique case (ctl.asel)
      c6502_pkg::AS_PC:  addr = pc_r;
      c6502_pkg::AS_ZP:  addr = {8'h00, zp};
      c6502_pkg::AS_ZP1: addr = {8'h00, 8'(zp + 8'd1)};
      c6502_pkg::AS_EFF: addr = eff;
      c6502_pkg::AS_CLR: addr = clr_r[c6502_pkg::AddrBits-1:0];
      c6502_pkg::AS_IN:  addr = in_address;
      default:           addr = pc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.mem_we)
      mem[addr[c6502_pkg::AddrBits-1:0]] <= ctl.asel == c6502_pkg::AS_IN ? in_data : 8'h00;
    if (ctl.mem_re) rdata_r <= mem[addr[c6502_pkg::AddrBits-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_op)  op_r  <= rdata_r;
    if (ctl.cap_lo)  lo_r  <= rdata_r;
    if (ctl.cap_plo) plo_r <= rdata_r;
    if (ctl.cap_val) val_r <= rdata_r;
    else if (ctl.cap_lo && mode == c6502_pkg::M_IMM) val_r <= rdata_r;
  end

  assign sum = {1'b0, acc_r} + {1'b0, val_r} + {8'h00, flags_r[0]};
  assign res = sum[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      pc_r <= '0;
      acc_r <= '0;
      x_r <= '0;
      y_r <= '0;
      flags_r <= '0;
      unk_r <= 1'b0;
    end else begin
      if (ctl.clr_inc) clr_r <= clr_r + 1'b1;
      if (ctl.load_in) unk_r <= 1'b0;
      if (ctl.set_unk) unk_r <= 1'b1;
      if (ctl.pc_load && in_sel == c6502_pkg::SEL_SETPC) pc_r <= in_address;
      else if (ctl.pc_inc) pc_r <= pc_r + 16'd1;
      if (ctl.exec) begin
        unique case (kind)
          c6502_pkg::K_ADC: begin
            acc_r <= res;
            flags_r <= {res[7], (~(acc_r[7] ^ val_r[7])) & (acc_r[7] ^ res[7]),
                        res == 8'h00, sum[8]};
          end
          c6502_pkg::K_LDA: begin
            acc_r <= val_r;
            flags_r <= {val_r[7], flags_r[2], val_r == 8'h00, flags_r[0]};
          end
          c6502_pkg::K_LDX: begin
            x_r <= val_r;
            flags_r <= {val_r[7], flags_r[2], val_r == 8'h00, flags_r[0]};
          end
          c6502_pkg::K_LDY: begin
            y_r <= val_r;
            flags_r <= {val_r[7], flags_r[2], val_r == 8'h00, flags_r[0]};
          end
          default: ;
        endcase
      end
    end
  end

  assign pc = pc_r;
  assign acc = acc_r;
  assign xr = x_r;
  assign yr = y_r;
  assign flags = flags_r;
  assign unk = unk_r;
endmodule

/* rtl/cpu6502_load_add_subset_core.sv */
// cpu6502_load_add_subset_core: top level of the 6502 load/add subset core.
// Depends on c6502_pkg, c6502_in_if, c6502_out_if, c6502_ctrl and c6502_dp.
//
//  channel | dir | contents
//  in      | in  | opcode (2), address (16), data (8)
//  out     | out | program_counter, accumulator, index_x, index_y, C Z V N, unknown_opcode
//
// Items pass through the single-port byte memory, one read per cycle: write, set-PC and
// ignored items need no read; an execute reads the opcode, then operand bytes, pointer
// bytes and the value as its mode needs (an unknown opcode stops after the opcode).
// After reset a clearing pass zeroes all 65536 bytes of the memory with in_ready low.
// Hold the result while out_ready is low; accept no item until it is taken.
module cpu6502_load_add_subset_core (
  input logic clk,
  input logic rst_n,
  c6502_in_if.sink    in_ch,
  c6502_out_if.source out_ch
);
  c6502_pkg::ctl_t ctl;
  c6502_pkg::sts_t sts;
  logic [3:0] flags;

  c6502_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready), .in_sel (in_ch.opcode),
    .out_valid (out_ch.valid), .out_ready (out_ch.ready),
    .sts, .ctl
  );

  c6502_dp u_dp (
    .clk, .rst_n, .ctl, .sts,
    .in_sel (in_ch.opcode), .in_address (in_ch.address), .in_data (in_ch.data),
    .pc (out_ch.program_counter), .acc (out_ch.accumulator),
    .xr (out_ch.index_x), .yr (out_ch.index_y), .flags,
    .unk (out_ch.unknown_opcode)
  );

  assign out_ch.carry_flag    = flags[0];
  assign out_ch.zero_flag     = flags[1];
  assign out_ch.overflow_flag = flags[2];
  assign out_ch.negative_flag = flags[3];
endmodule

/* rtl/c6502_chk.sv */
// c6502_chk: port checker for the core, bound to the top level.
// Depends on c6502_pkg, c6502_in_if and c6502_out_if.
module c6502_chk (
  input logic clk,
  input logic rst_n,
  c6502_in_if.sink    in_ch,
  c6502_out_if.source out_ch
);
  // one item at a time: never ready while a result waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  a_pc: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.program_counter))
    else $error("pc moved while stalled");
  a_setpc: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.opcode == c6502_pkg::SEL_SETPC |=> ##1
    out_ch.program_counter == $past(in_ch.address, 2)) else $error("set pc");
endmodule

bind cpu6502_load_add_subset_core c6502_chk u_chk (.clk, .rst_n, .in_ch, .out_ch);
